>>> sv/gcw_pkg.sv
// shared types, constants and register map of the windowed gc content plotter
package gcw_pkg;

	// counts saturate here
	localparam int unsigned MAX_WINDOW = 65535;

	// window queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// restoring divider: 17 quotient bits, fraction is 0..65536
	localparam int unsigned FRAC_W    = 17;
	localparam int unsigned DIV_STEPS = FRAC_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// scaling datapath widths
	localparam int unsigned DIFF_W = FRAC_W + 1;
	localparam int unsigned M1_W   = DIFF_W + 13;
	localparam int unsigned P_W    = M1_W + 9;
	localparam int unsigned RND_SHIFT = 24;
	localparam logic [P_W-1:0] ROUND_HALF = P_W'(1) << (RND_SHIFT - 1);

	// base characters
	localparam logic [7:0] CHAR_N = 8'h6e;
	localparam logic [7:0] CHAR_C = 8'h63;
	localparam logic [7:0] CHAR_G = 8'h67;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MIN_REAL  = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_GC_FLOOR  = 3'd2;
	localparam logic [2:0] REG_GC_GAIN   = 3'd3;
	localparam logic [2:0] REG_LINE_MODE = 3'd4;
	localparam logic [2:0] REG_THICK     = 3'd5;

	// register reset values
	localparam logic [15:0] RST_MIN_REAL  = 16'd20;
	localparam logic [7:0]  RST_HEIGHT    = 8'd75;
	localparam logic [15:0] RST_GC_FLOOR  = 16'd20316;
	localparam logic [11:0] RST_GC_GAIN   = 12'd853;
	localparam logic        RST_LINE_MODE = 1'b1;
	localparam logic        RST_THICK     = 1'b0;

	typedef struct packed {
		logic [7:0] base;
		logic       window_end;
	} item_t;

	typedef struct packed {
		logic [15:0] column;
		logic [7:0]  row_from;
		logic [7:0]  row_to;
		logic        is_segment;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] min_real_count;
		logic [7:0]  plot_height;
		logic [15:0] gc_floor_q16;
		logic [11:0] gc_gain_q8;
		logic        line_mode;
		logic        thick;
	} cfg_t;

	// one closed window as handed from front to back
	typedef struct packed {
		logic [15:0] column;
		logic [15:0] real_count;
		logic [15:0] gc_count;
		logic        too_small;
	} win_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_MUL1,
		B_MUL2,
		B_ROW,
		B_EMIT0,
		B_EMIT1
	} bstate_t;

endpackage

>>> sv/gc_content_window_plotter.sv
// top level of the windowed gc content plotter: register port, front, queue, back
//
//  channel   direction  handshake            payload
//  item      in         push / full          base, window_end
//  result    out        empty / pop          column, row_from, row_to, is_segment, last
//  config    in         psel/penable/pready  paddr[4:2] selects register, pwdata / prdata
//
//  the front takes one base per cycle for as long as the window queue has room
//  the back drops a window too small to plot in idle; a dot takes the 17-step
//  divider, the shared two-stage multiplier, a row step and an emit, a segment
//  one more multiplier pass and row step, and thick mode one more emit
//  reset (arst_n low) clears counters, queue, sequencer and loads register defaults
//  full follows the queue; a result waiting on pop stalls only the back
module gc_content_window_plotter (
	input  logic             clk,
	input  logic             arst_n,
	// item requests
	input  logic             push,
	output logic             full,
	input  gcw_pkg::item_t   item,
	// result requests
	output logic             empty,
	input  logic             pop,
	output gcw_pkg::result_t result,
	// register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	gcw_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	gcw_pkg::win_t front_win;
	gcw_pkg::win_t back_win;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;

	// register port: zero wait states, write at the access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_real_count <= gcw_pkg::RST_MIN_REAL;
			cfg_q.plot_height    <= gcw_pkg::RST_HEIGHT;
			cfg_q.gc_floor_q16   <= gcw_pkg::RST_GC_FLOOR;
			cfg_q.gc_gain_q8     <= gcw_pkg::RST_GC_GAIN;
			cfg_q.line_mode      <= gcw_pkg::RST_LINE_MODE;
			cfg_q.thick          <= gcw_pkg::RST_THICK;
		end else if (wr_en) begin
			unique case (reg_idx)
				gcw_pkg::REG_MIN_REAL:  cfg_q.min_real_count <= pwdata[15:0];
				gcw_pkg::REG_HEIGHT:    cfg_q.plot_height    <= pwdata[7:0];
				gcw_pkg::REG_GC_FLOOR:  cfg_q.gc_floor_q16   <= pwdata[15:0];
				gcw_pkg::REG_GC_GAIN:   cfg_q.gc_gain_q8     <= pwdata[11:0];
				gcw_pkg::REG_LINE_MODE: cfg_q.line_mode      <= pwdata[0];
				gcw_pkg::REG_THICK:     cfg_q.thick          <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// read back; unmapped addresses read zero
	always_comb begin
		unique case (reg_idx)
			gcw_pkg::REG_MIN_REAL:  prdata = {16'b0, cfg_q.min_real_count};
			gcw_pkg::REG_HEIGHT:    prdata = {24'b0, cfg_q.plot_height};
			gcw_pkg::REG_GC_FLOOR:  prdata = {16'b0, cfg_q.gc_floor_q16};
			gcw_pkg::REG_GC_GAIN:   prdata = {20'b0, cfg_q.gc_gain_q8};
			gcw_pkg::REG_LINE_MODE: prdata = {31'b0, cfg_q.line_mode};
			gcw_pkg::REG_THICK:     prdata = {31'b0, cfg_q.thick};
			default:                prdata = '0;
		endcase
	end

	// front: counts bases and closes windows into the queue
	gcw_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.item           (item),
		.min_real_count (cfg_q.min_real_count),
		.q_full         (q_full),
		.full           (full),
		.q_push         (q_push),
		.q_data         (front_win)
	);

	// closed windows waiting for the back
	gcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_win),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (back_win),
		.empty  (q_empty)
	);

	// back: divide, scale, emit one or two marks per plotted window
	gcw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (back_win),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

>>> sv/gcw_front.sv
// front part: base classification, window counters and window close
module gcw_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gcw_pkg::item_t item,
	input  logic [15:0]   min_real_count,
	input  logic          q_full,
	output logic          full,
	output logic          q_push,
	output gcw_pkg::win_t q_data
);

	logic [15:0] real_q;
	logic [15:0] gc_q;
	logic [15:0] index_q;
	logic [15:0] real_nx;
	logic [15:0] gc_nx;
	logic        is_real;
	logic        is_gc;
	logic        take;

	always_comb begin
		is_real = item.base != gcw_pkg::CHAR_N;
		is_gc   = (item.base == gcw_pkg::CHAR_C) || (item.base == gcw_pkg::CHAR_G);
		real_nx = real_q;
		gc_nx   = gc_q;
		if (is_real && real_q != 16'(gcw_pkg::MAX_WINDOW)) begin
			real_nx = real_q + 16'd1;
		end
		if (is_gc && gc_q != 16'(gcw_pkg::MAX_WINDOW)) begin
			gc_nx = gc_q + 16'd1;
		end
		full  = q_full;
		take  = push && !q_full;
		q_push = take && item.window_end;
		q_data.column     = index_q;
		q_data.real_count = real_nx;
		q_data.gc_count   = gc_nx;
		q_data.too_small  = (real_nx == 16'd0) || (real_nx < min_real_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_q  <= '0;
			gc_q    <= '0;
			index_q <= '0;
		end else if (take) begin
			if (item.window_end) begin
				real_q  <= '0;
				gc_q    <= '0;
				index_q <= index_q + 16'd1;
			end else begin
				real_q <= real_nx;
				gc_q   <= gc_nx;
			end
		end
	end

endmodule

>>> sv/gcw_queue.sv
// short queue of closed windows between front and back
module gcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gcw_pkg::win_t wdata,
	output logic          full,
	input  logic          pop,
	output gcw_pkg::win_t rdata,
	output logic          empty
);

	gcw_pkg::win_t                   mem_q [gcw_pkg::QDEPTH];
	logic [gcw_pkg::QPTR_W-1:0]      wptr_q;
	logic [gcw_pkg::QPTR_W-1:0]      rptr_q;
	logic [gcw_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = count_q == gcw_pkg::QCNT_W'(gcw_pkg::QDEPTH);
	assign empty   = count_q == '0;
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + gcw_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + gcw_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + gcw_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - gcw_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/gcw_back.sv
// back part: gc fraction divider, row scaling and result register
module gcw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gcw_pkg::cfg_t   cfg,
	input  logic            q_empty,
	input  gcw_pkg::win_t   q_data,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output gcw_pkg::result_t result
);

	gcw_pkg::bstate_t                 state_q;
	gcw_pkg::bstate_t                 state_d;
	logic [gcw_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [15:0]                      rem_q;
	logic [gcw_pkg::FRAC_W-1:0]       dsh_q;
	logic [gcw_pkg::FRAC_W-1:0]       quo_q;
	logic [15:0]                      div_d_q;
	logic [15:0]                      col_q;
	logic [gcw_pkg::FRAC_W-1:0]       frac_q;
	logic [gcw_pkg::FRAC_W-1:0]       prev_frac_q;
	logic                             prev_missing_q;
	logic                             pass_q;
	logic signed [gcw_pkg::M1_W-1:0]  m1_s1;
	logic signed [gcw_pkg::P_W-1:0]   p_s2;
	logic [7:0]                       to_q;
	logic [7:0]                       from_q;
	logic                             seg_q;
	gcw_pkg::result_t                 out_q;
	logic                             out_valid_q;

	logic [16:0]                      trial;
	logic                             ge;
	logic [15:0]                      rem_nx;
	logic [gcw_pkg::FRAC_W-1:0]       quo_nx;
	logic signed [8:0]                rng9;
	logic [7:0]                       range;
	logic [gcw_pkg::FRAC_W-1:0]       opnd;
	logic signed [gcw_pkg::DIFF_W-1:0] diff;
	logic                             neg;
	logic [gcw_pkg::P_W-1:0]          mag;
	logic [gcw_pkg::P_W-1:0]          mag_r;
	logic signed [15:0]               k;
	logic signed [15:0]               row16;
	logic [7:0]                       row;
	logic                             out_free;
	logic                             want_seg;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// datapath combinational parts
	always_comb begin
		trial  = {rem_q, dsh_q[gcw_pkg::FRAC_W-1]};
		ge     = trial >= {1'b0, div_d_q};
		rem_nx = ge ? 16'(trial - {1'b0, div_d_q}) : trial[15:0];
		quo_nx = {quo_q[gcw_pkg::FRAC_W-2:0], ge};

		// degenerate height falls back to one row
		rng9 = $signed({1'b0, cfg.plot_height}) - $signed({8'b0, cfg.thick});
		if (rng9 < 9'sd1) begin
			range = 8'd1;
		end else begin
			range = rng9[7:0];
		end

		opnd = pass_q ? prev_frac_q : frac_q;
		diff = $signed({1'b0, opnd}) - $signed({2'b0, cfg.gc_floor_q16});

		// round half away from zero
		neg   = p_s2[gcw_pkg::P_W-1];
		mag   = neg ? gcw_pkg::P_W'(-p_s2) : gcw_pkg::P_W'(p_s2);
		mag_r = mag + gcw_pkg::ROUND_HALF;
		k     = $signed(mag_r[gcw_pkg::RND_SHIFT+15:gcw_pkg::RND_SHIFT]);
		if (neg) begin
			k = -k;
		end
		row16 = $signed({8'b0, range}) - 16'sd1 - k;
		if (row16 < 16'sd0) begin
			row = 8'd0;
		end else if (row16 >= $signed({8'b0, range})) begin
			row = range - 8'd1;
		end else begin
			row = row16[7:0];
		end

		out_free = !out_valid_q || pop;
		want_seg = cfg.line_mode && !prev_missing_q;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			gcw_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (!q_data.too_small) begin
						state_d = gcw_pkg::B_DIV;
					end
				end
			end
			gcw_pkg::B_DIV: begin
				if (cnt_q == '0) begin
					state_d = gcw_pkg::B_MUL1;
				end
			end
			gcw_pkg::B_MUL1: state_d = gcw_pkg::B_MUL2;
			gcw_pkg::B_MUL2: state_d = gcw_pkg::B_ROW;
			gcw_pkg::B_ROW: begin
				if (!pass_q && want_seg) begin
					state_d = gcw_pkg::B_MUL1;
				end else begin
					state_d = gcw_pkg::B_EMIT0;
				end
			end
			gcw_pkg::B_EMIT0: begin
				if (out_free) begin
					state_d = cfg.thick ? gcw_pkg::B_EMIT1 : gcw_pkg::B_IDLE;
				end
			end
			gcw_pkg::B_EMIT1: begin
				if (out_free) begin
					state_d = gcw_pkg::B_IDLE;
				end
			end
			default: state_d = gcw_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcw_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_missing_q <= 1'b1;
			prev_frac_q    <= '0;
			pass_q         <= 1'b0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			unique case (state_q)
				gcw_pkg::B_IDLE: begin
					if (!q_empty && q_data.too_small) begin
						prev_missing_q <= 1'b1;
					end
					pass_q <= 1'b0;
					cnt_q  <= gcw_pkg::DIV_CNT_W'(gcw_pkg::DIV_STEPS - 1);
				end
				gcw_pkg::B_DIV: begin
					cnt_q <= cnt_q - gcw_pkg::DIV_CNT_W'(1);
				end
				gcw_pkg::B_ROW: begin
					if (!pass_q && want_seg) begin
						pass_q <= 1'b1;
					end else begin
						prev_frac_q    <= frac_q;
						prev_missing_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if ((state_q == gcw_pkg::B_EMIT0 || state_q == gcw_pkg::B_EMIT1) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			gcw_pkg::B_IDLE: begin
				col_q   <= q_data.column;
				div_d_q <= q_data.real_count;
				rem_q   <= {1'b0, q_data.gc_count[15:1]};
				dsh_q   <= {q_data.gc_count[0], 16'b0};
				quo_q   <= '0;
			end
			gcw_pkg::B_DIV: begin
				rem_q <= rem_nx;
				dsh_q <= {dsh_q[gcw_pkg::FRAC_W-2:0], 1'b0};
				quo_q <= quo_nx;
				if (cnt_q == '0) begin
					frac_q <= quo_nx;
				end
			end
			gcw_pkg::B_MUL1: begin
				m1_s1 <= gcw_pkg::M1_W'(diff * $signed({1'b0, cfg.gc_gain_q8}));
			end
			gcw_pkg::B_MUL2: begin
				p_s2 <= gcw_pkg::P_W'(m1_s1 * $signed({1'b0, range}));
			end
			gcw_pkg::B_ROW: begin
				if (!pass_q) begin
					to_q <= row;
					if (!want_seg) begin
						from_q <= row;
						seg_q  <= 1'b0;
					end
				end else begin
					from_q <= row;
					seg_q  <= 1'b1;
				end
			end
			gcw_pkg::B_EMIT0: begin
				if (out_free) begin
					out_q.column     <= col_q;
					out_q.row_from   <= from_q;
					out_q.row_to     <= to_q;
					out_q.is_segment <= seg_q;
					out_q.last       <= !cfg.thick;
				end
			end
			gcw_pkg::B_EMIT1: begin
				if (out_free) begin
					out_q.column     <= col_q;
					out_q.row_from   <= from_q + 8'd1;
					out_q.row_to     <= to_q + 8'd1;
					out_q.is_segment <= seg_q;
					out_q.last       <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/gcw_checker.sv
// port-level checker of the windowed gc content plotter and its bind
module gcw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input gcw_pkg::result_t result,
	input logic             pready
);

	// register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	// a dot starts and ends on the same row
	a_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_segment) |-> (result.row_from == result.row_to))
		else $error("dot with differing rows");

	// the first mark of a thick pair is followed at once by its copy
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last) |=>
		(!empty && result.last && result.column == $past(result.column)))
		else $error("thick copy missing");

endmodule

bind gc_content_window_plotter gcw_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result),
	.pready (pready)
);

>>> sim/gcw_plot_checker.sv
// checker for the gc content plotter: mirrors the register port, predicts marks, compares results
module gcw_plot_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  gcw_pkg::item_t           item,
	input  logic                     empty,
	input  logic                     pop,
	input  gcw_pkg::result_t         result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [4:0]               paddr,
	input  logic [31:0]              pwdata,
	output int                       errors,
	output int                       pending
);
	import gcw_pkg::*;

	cfg_t        cfg;
	logic [15:0] real_cnt;
	logic [15:0] gc_cnt;
	logic [15:0] col_idx;
	logic [16:0] last_frac;
	logic        last_gap;
	result_t     marks_due[$];

	// inverted, clamped plot row for a q1.16 fraction
	function automatic logic [7:0] row_for(logic [16:0] frac, int span, cfg_t c);
		longint diff;
		longint p;
		longint k;
		longint row;
		diff = longint'(frac) - longint'(c.gc_floor_q16);
		p = diff * longint'(c.gc_gain_q8) * longint'(span);
		if (p >= 0) begin
			k = (p + 64'sh800000) >>> 24;
		end else begin
			k = -(((-p) + 64'sh800000) >>> 24);
		end
		row = longint'(span) - 1 - k;
		if (row < 0) row = 0;
		if (row >= span) row = span - 1;
		return row[7:0];
	endfunction

	// counts one base and queues the marks a closed window produces
	task automatic predict_marks(item_t it);
		result_t         mark;
		longint unsigned quo;
		logic [16:0]     frac;
		int              span;
		logic [7:0]      to_row;
		logic [7:0]      from_row;
		logic            seg;
		logic [15:0]     col;
		if (it.base != CHAR_N && real_cnt < MAX_WINDOW) real_cnt = real_cnt + 16'd1;
		if ((it.base == CHAR_C || it.base == CHAR_G) && gc_cnt < MAX_WINDOW)
			gc_cnt = gc_cnt + 16'd1;
		if (it.window_end) begin
			col = col_idx;
			col_idx = col_idx + 16'd1;
			if (real_cnt == 16'd0 || real_cnt < cfg.min_real_count) begin
				last_gap = 1'b1;
			end else begin
				quo = (longint'(gc_cnt) << 16) / longint'(real_cnt);
				if (quo > 65536) quo = 65536;
				frac = quo[16:0];
				span = int'(cfg.plot_height) - int'(cfg.thick);
				if (span < 1) span = 1;
				to_row = row_for(frac, span, cfg);
				if (cfg.line_mode && !last_gap) begin
					from_row = row_for(last_frac, span, cfg);
					seg = 1'b1;
				end else begin
					from_row = to_row;
					seg = 1'b0;
				end
				mark = '{column: col, row_from: from_row, row_to: to_row,
					is_segment: seg, last: !cfg.thick};
				marks_due.push_back(mark);
				if (cfg.thick) begin
					mark.row_from = from_row + 8'd1;
					mark.row_to = to_row + 8'd1;
					mark.last = 1'b1;
					marks_due.push_back(mark);
				end
				last_frac = frac;
				last_gap = 1'b0;
			end
			real_cnt = '0;
			gc_cnt = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		logic    bad;
		if (!arst_n) begin
			cfg.min_real_count = RST_MIN_REAL;
			cfg.plot_height = RST_HEIGHT;
			cfg.gc_floor_q16 = RST_GC_FLOOR;
			cfg.gc_gain_q8 = RST_GC_GAIN;
			cfg.line_mode = RST_LINE_MODE;
			cfg.thick = RST_THICK;
			real_cnt = '0;
			gc_cnt = '0;
			col_idx = '0;
			last_frac = '0;
			last_gap = 1'b1;
			marks_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (marks_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: col %0d from %0d to %0d seg %0b last %0b",
							result.column, result.row_from, result.row_to,
							result.is_segment, result.last);
					errors = errors + 1;
				end else begin
					want = marks_due.pop_front();
					bad = (result.column !== want.column) || (result.row_from !== want.row_from)
						|| (result.row_to !== want.row_to)
						|| (result.is_segment !== want.is_segment)
						|| (result.last !== want.last);
					if (bad) begin
						if (errors < 10)
							$display("mismatch: expected col %0d from %0d to %0d seg %0b last %0b, got col %0d from %0d to %0d seg %0b last %0b",
								want.column, want.row_from, want.row_to, want.is_segment,
								want.last, result.column, result.row_from, result.row_to,
								result.is_segment, result.last);
						errors = errors + 1;
					end
				end
			end
			if (push && !full) predict_marks(item);
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MIN_REAL:  cfg.min_real_count = pwdata[15:0];
					REG_HEIGHT:    cfg.plot_height = pwdata[7:0];
					REG_GC_FLOOR:  cfg.gc_floor_q16 = pwdata[15:0];
					REG_GC_GAIN:   cfg.gc_gain_q8 = pwdata[11:0];
					REG_LINE_MODE: cfg.line_mode = pwdata[0];
					REG_THICK:     cfg.thick = pwdata[0];
					default: ;
				endcase
			end
			pending = marks_due.size();
		end
	end

endmodule

>>> sim/testbench.sv
// testbench top for the gc content plotter: stimulus, register setup, verdict
module testbench;
	import gcw_pkg::*;

	// other base characters used by the stimulus
	localparam logic [7:0] CHAR_A  = 8'h61;
	localparam logic [7:0] CHAR_T  = 8'h74;
	localparam logic [7:0] CHAR_UC = 8'h43;
	localparam logic [7:0] CHAR_UG = 8'h47;
	localparam logic [7:0] CHAR_UN = 8'h4e;

	// the window queue between front and back holds 4
	localparam int QUIET_CYCLES = 200;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	item_t       item;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;

	int send_gap_pct;
	int recv_gap_pct;
	bit hold_req = 1'b0;
	int hold_left;
	int items_sent;
	int cur_min;

	gc_content_window_plotter dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	gcw_plot_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random pop, or a long hold-off when asked
	initial begin
		pop <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	// one item request; returns at the edge that accepts it
	task automatic send(input logic [7:0] b, input logic wend);
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{base: b, window_end: wend};
		// full is stable at the falling edge, so this tells whether the next edge takes it
		forever begin
			@(negedge clk);
			if (!full) break;
		end
		@(posedge clk);
		items_sent = items_sent + 1;
	endtask

	// stop offering, drain all expected results, then let silent windows finish
	task automatic quiet();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// setup then access phase; the access edge writes the register
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			if (pready) break;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input int mn, input int height, input int flr, input int gain,
		input bit line, input bit thk);
		cfg_write(REG_MIN_REAL, mn);
		cfg_write(REG_HEIGHT, height);
		cfg_write(REG_GC_FLOOR, flr);
		cfg_write(REG_GC_GAIN, gain);
		cfg_write(REG_LINE_MODE, 32'(line));
		cfg_write(REG_THICK, 32'(thk));
		cur_min = mn;
	endtask

	// mostly real bases, some unknowns, some arbitrary bytes
	function automatic logic [7:0] pick_base();
		int r;
		r = $urandom_range(99);
		if (r < 45) return ($urandom_range(1) != 0) ? CHAR_C : CHAR_G;
		if (r < 80) return ($urandom_range(1) != 0) ? CHAR_A : CHAR_T;
		if (r < 90) return CHAR_N;
		return 8'($urandom_range(255));
	endfunction

	// window length around the plotting threshold, some fall short of it
	function automatic int pick_len();
		if (cur_min <= 8) return $urandom_range(1, 10);
		return cur_min - 2 + $urandom_range(0, 6);
	endfunction

	task automatic send_window(input int len);
		for (int i = 0; i < len; i++) send(pick_base(), i == len - 1);
	endtask

	// random register settings with the extremes weighted in, then random windows
	task automatic random_phase(input int n_sub);
		int start;
		int mn;
		int height;
		int flr;
		int gain;
		int r;
		repeat (n_sub) begin
			mn = ($urandom_range(5) == 0) ? 20 : $urandom_range(8);
			r = $urandom_range(4);
			height = (r == 0) ? 2 : (r == 1) ? 255 : $urandom_range(2, 255);
			r = $urandom_range(4);
			flr = (r == 0) ? 0 : (r == 1) ? 65535 : (r == 2) ? 20316 : $urandom_range(65535);
			r = $urandom_range(6);
			gain = (r == 0) ? 1 : (r == 1) ? 4095 : $urandom_range(1, 4095);
			set_all(mn, height, flr, gain, 1'($urandom_range(1)), 1'($urandom_range(1)));
			start = items_sent;
			while (items_sent - start < 32) send_window(pick_len());
			quiet();
		end
	endtask

	initial begin
		push <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		items_sent = 0;
		cur_min = int'(RST_MIN_REAL);
		send_gap_pct = 12;
		recv_gap_pct = 67;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest scale, line mode, no thick
		set_all(0, 255, 0, 4095, 1, 0);
		// window of unknowns only: no real bases, no mark
		send(CHAR_N, 1'b0);
		send(CHAR_N, 1'b1);
		// all gc: full fraction, dot after the gap
		send(CHAR_C, 1'b1);
		// byte extremes count as real, not gc: zero fraction, segment
		send(8'h00, 1'b0);
		send(8'hff, 1'b1);
		// uppercase letters are real but never gc
		send(CHAR_UC, 1'b0);
		send(CHAR_UG, 1'b0);
		send(CHAR_UN, 1'b1);
		quiet();

		// thick on the smallest height leaves a single row; dots only
		set_all(3, 2, 65535, 1, 0, 1);
		// short of the threshold: no mark, breaks the line
		send(CHAR_G, 1'b0);
		send(CHAR_C, 1'b1);
		send(CHAR_G, 1'b0);
		send(CHAR_C, 1'b0);
		send(CHAR_A, 1'b1);
		send(CHAR_T, 1'b0);
		send(CHAR_N, 1'b0);
		send(CHAR_C, 1'b0);
		send(CHAR_G, 1'b1);
		quiet();

		// default scale with thick segments
		set_all(1, 75, 20316, 853, 1, 1);
		send(CHAR_C, 1'b0);
		send(CHAR_A, 1'b1);
		send(CHAR_G, 1'b0);
		send(CHAR_T, 1'b1);
		send(CHAR_A, 1'b1);
		quiet();

		// back to the reset values for the first random stretch
		set_all(int'(RST_MIN_REAL), int'(RST_HEIGHT), int'(RST_GC_FLOOR), int'(RST_GC_GAIN),
			RST_LINE_MODE, RST_THICK);
		repeat (3) send_window(pick_len());
		quiet();

		random_phase(3);

		send_gap_pct = 67;
		recv_gap_pct = 12;
		random_phase(3);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		random_phase(3);

		// result side holds off while short windows keep coming: queue fills, full rises
		set_all(0, 100, 10000, 600, 1, 1);
		hold_req = 1'b1;
		repeat (30) send_window($urandom_range(1, 2));
		quiet();

		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
